// File: rtl/owb_pkg.sv
// Shared types and constants for the 1-Wire bus master.
package owb_pkg;

	localparam int REG_W  = 10;
	localparam int LEN_W  = REG_W + 1;
	localparam int DATA_W = 8;

	typedef enum logic [2:0] {
		KIND_TICK       = 3'd0,
		KIND_RESET      = 3'd1,
		KIND_WRITE_BIT  = 3'd2,
		KIND_READ_BIT   = 3'd3,
		KIND_WRITE_BYTE = 3'd4,
		KIND_READ_BYTE  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_LOW      = 3'd1,
		PH_RELEASE  = 3'd2,
		PH_SAMPLE   = 3'd3,
		PH_TAIL     = 3'd4,
		PH_RST_LOW  = 3'd5,
		PH_RST_WAIT = 3'd6,
		PH_RST_TAIL = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		REG_ONE_LOW      = 3'd0,
		REG_ZERO_LOW     = 3'd1,
		REG_RESET_LOW    = 3'd2,
		REG_PRESENCE_WAIT = 3'd3,
		REG_RESET_TAIL   = 3'd4,
		REG_SAMPLE_WAIT  = 3'd5,
		REG_READ_TAIL    = 3'd6
	} reg_idx_t;

	localparam logic [REG_W-1:0] ONE_LOW_RST       = 10'd10;
	localparam logic [REG_W-1:0] ZERO_LOW_RST      = 10'd60;
	localparam logic [REG_W-1:0] RESET_LOW_RST     = 10'd500;
	localparam logic [REG_W-1:0] PRESENCE_WAIT_RST = 10'd70;
	localparam logic [REG_W-1:0] RESET_TAIL_RST    = 10'd410;
	localparam logic [REG_W-1:0] SAMPLE_WAIT_RST   = 10'd15;
	localparam logic [REG_W-1:0] READ_TAIL_RST     = 10'd50;

	localparam logic [LEN_W-1:0] READ_LOW_TICKS  = 11'd5;
	localparam logic [LEN_W-1:0] ZERO_HIGH_TICKS = 11'd5;

	localparam logic [3:0] BYTE_BITS_LEFT = 4'd7;

endpackage

// File: rtl/owb_ifs.sv
// Command and result channel interfaces of the 1-Wire bus master.
interface owb_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] write_data;
	logic       line_level;

	modport source (output valid, output kind, output write_data, output line_level,
		input ready);
	modport sink (input valid, input kind, input write_data, input line_level,
		output ready);
endinterface

interface owb_rsp_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       rejected;
	logic [7:0] read_data;
	logic       presence;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output rejected, output read_data, output presence, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input rejected, input read_data, input presence, output ready);
endinterface

// File: rtl/one_wire_bus_master.sv
// 1-Wire bus master timed by microsecond tick beats.
//
// cmd carries one beat per microsecond tick (kind tick, with the sampled bus
// level) or a command (reset, write bit, read bit, write byte, read byte).
// A command is taken only while idle; one that arrives while busy is
// reported as rejected and changes nothing. Every cmd beat yields exactly
// one rsp beat: drive_low for the coming microsecond, busy, done, rejected,
// read data on completion of a read, and the held presence flag.
// The rsp beat is in the output register on the cycle after its cmd beat.
// One beat is taken per cycle while rsp does not stall; the state update is
// a single pass of logic between the state registers and the output register.
// When rsp stalls, the output register holds its beat and cmd ready drops
// until that beat is taken; the beat after it is then taken in the same
// cycle the held one leaves.
// cfg writes one of seven 10-bit timing registers per cycle with cfg_wr_en;
// write only while idle. Indexes past six are ignored.
// Reset clears the sequencer to idle, presence to zero, the rsp register to
// empty and loads the default timings.
module one_wire_bus_master #(
	parameter int COUNT_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	owb_cmd_if.sink                   cmd,
	owb_rsp_if.source                 rsp,
	input  logic                      cfg_wr_en,
	input  logic [2:0]                cfg_index,
	input  logic [owb_pkg::REG_W-1:0] cfg_wdata
);
	import owb_pkg::*;

	localparam int FW = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	function automatic logic [COUNT_BITS-1:0] fit_len(input logic [LEN_W-1:0] v,
		input logic at_least_one);
		logic [FW-1:0] w;
		w = FW'(v);
		if (at_least_one && (v == '0)) w = FW'(1);
		if (w > FW'(CNT_MAX)) w = FW'(CNT_MAX);
		return w[COUNT_BITS-1:0];
	endfunction

	logic [REG_W-1:0] one_low_q, zero_low_q, reset_low_q, presence_wait_q;
	logic [REG_W-1:0] reset_tail_q, sample_wait_q, read_tail_q;

	phase_t                  phase_q, n_phase;
	logic [COUNT_BITS-1:0]   tick_count_q, n_count, cnt_dec;
	logic [3:0]              bits_left_q, n_bits;
	logic [DATA_W-1:0]       shift_q, n_shift;
	logic                    op_read_q, n_read;
	logic                    op_byte_q, n_byte;
	logic                    presence_q, n_presence;
	logic                    cur_bit_q, n_cur;

	logic                    slot_end, slot_start, done_c, rej_c;
	logic [DATA_W-1:0]       rdata_c;
	logic [LEN_W-1:0]        high_time;
	logic                    cmd_fire;

	logic                    rsp_valid_q;
	logic                    drive_low_q, busy_q, done_q, rejected_q, presence_out_q;
	logic [DATA_W-1:0]       read_data_q;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cnt_dec   = tick_count_q - COUNT_BITS'(1);

	always_comb begin
		if (cur_bit_q && (zero_low_q > one_low_q)) begin
			high_time = LEN_W'(zero_low_q) - LEN_W'(one_low_q) + ZERO_HIGH_TICKS;
		end else begin
			high_time = ZERO_HIGH_TICKS;
		end
	end

	always_comb begin
		n_phase    = phase_q;
		n_count    = tick_count_q;
		n_bits     = bits_left_q;
		n_shift    = shift_q;
		n_read     = op_read_q;
		n_byte     = op_byte_q;
		n_presence = presence_q;
		n_cur      = cur_bit_q;
		slot_end   = 1'b0;
		slot_start = 1'b0;
		done_c     = 1'b0;
		rej_c      = 1'b0;
		rdata_c    = '0;

		if (cmd_fire) begin
			if (cmd.kind == KIND_TICK) begin
				if (phase_q != PH_IDLE) begin
					n_count = cnt_dec;
					if (cnt_dec == '0) begin
						case (phase_q)
							PH_LOW: begin
								if (op_read_q) begin
									n_phase = PH_SAMPLE;
									n_count = fit_len(LEN_W'(sample_wait_q), 1'b1);
								end else begin
									n_phase = PH_RELEASE;
									n_count = fit_len(high_time, 1'b1);
								end
							end
							PH_RELEASE, PH_TAIL: slot_end = 1'b1;
							PH_SAMPLE: begin
								n_cur   = cmd.line_level;
								n_shift = {cmd.line_level, shift_q[DATA_W-1:1]};
								if (read_tail_q == '0) begin
									slot_end = 1'b1;
								end else begin
									n_phase = PH_TAIL;
									n_count = fit_len(LEN_W'(read_tail_q), 1'b0);
								end
							end
							PH_RST_LOW: begin
								n_phase = PH_RST_WAIT;
								n_count = fit_len(LEN_W'(presence_wait_q), 1'b1);
							end
							PH_RST_WAIT: begin
								n_presence = !cmd.line_level;
								if (reset_tail_q == '0) begin
									n_phase = PH_IDLE;
									done_c  = 1'b1;
								end else begin
									n_phase = PH_RST_TAIL;
									n_count = fit_len(LEN_W'(reset_tail_q), 1'b0);
								end
							end
							default: begin
								n_phase = PH_IDLE;
								done_c  = 1'b1;
							end
						endcase
					end
				end
			end else if (cmd.kind <= KIND_READ_BYTE) begin
				if (phase_q != PH_IDLE) begin
					rej_c = 1'b1;
				end else begin
					n_bits  = '0;
					n_shift = '0;
					n_byte  = 1'b0;
					n_read  = 1'b0;
					if (cmd.kind == KIND_RESET) begin
						n_phase = PH_RST_LOW;
						n_count = fit_len(LEN_W'(reset_low_q), 1'b1);
					end else begin
						slot_start = 1'b1;
						if ((cmd.kind == KIND_READ_BIT) || (cmd.kind == KIND_READ_BYTE)) begin
							n_read = 1'b1;
						end
						if ((cmd.kind == KIND_WRITE_BYTE) || (cmd.kind == KIND_READ_BYTE)) begin
							n_byte = 1'b1;
							n_bits = BYTE_BITS_LEFT;
						end
						if (cmd.kind == KIND_WRITE_BIT) begin
							n_shift = {{(DATA_W-1){1'b0}}, cmd.write_data[0]};
						end
						if (cmd.kind == KIND_WRITE_BYTE) begin
							n_shift = cmd.write_data;
						end
					end
				end
			end
		end

		if (slot_end) begin
			if (bits_left_q != '0) begin
				n_bits = bits_left_q - 4'd1;
				if (!op_read_q) n_shift = n_shift >> 1;
				slot_start = 1'b1;
			end else begin
				n_phase = PH_IDLE;
				done_c  = 1'b1;
				if (op_read_q) begin
					rdata_c = op_byte_q ? n_shift : {{(DATA_W-1){1'b0}}, n_cur};
				end
			end
		end

		if (slot_start) begin
			n_phase = PH_LOW;
			if (n_read) begin
				n_count = fit_len(READ_LOW_TICKS, 1'b1);
			end else begin
				n_cur   = n_shift[0];
				n_count = fit_len(n_cur ? LEN_W'(one_low_q) : LEN_W'(zero_low_q), 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_count_q <= '0;
			bits_left_q  <= '0;
			shift_q      <= '0;
			op_read_q    <= 1'b0;
			op_byte_q    <= 1'b0;
			presence_q   <= 1'b0;
			cur_bit_q    <= 1'b0;
		end else begin
			phase_q      <= n_phase;
			tick_count_q <= n_count;
			bits_left_q  <= n_bits;
			shift_q      <= n_shift;
			op_read_q    <= n_read;
			op_byte_q    <= n_byte;
			presence_q   <= n_presence;
			cur_bit_q    <= n_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_low_q       <= ONE_LOW_RST;
			zero_low_q      <= ZERO_LOW_RST;
			reset_low_q     <= RESET_LOW_RST;
			presence_wait_q <= PRESENCE_WAIT_RST;
			reset_tail_q    <= RESET_TAIL_RST;
			sample_wait_q   <= SAMPLE_WAIT_RST;
			read_tail_q     <= READ_TAIL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ONE_LOW:       one_low_q       <= cfg_wdata;
				REG_ZERO_LOW:      zero_low_q      <= cfg_wdata;
				REG_RESET_LOW:     reset_low_q     <= cfg_wdata;
				REG_PRESENCE_WAIT: presence_wait_q <= cfg_wdata;
				REG_RESET_TAIL:    reset_tail_q    <= cfg_wdata;
				REG_SAMPLE_WAIT:   sample_wait_q   <= cfg_wdata;
				REG_READ_TAIL:     read_tail_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			drive_low_q    <= (n_phase == PH_LOW) || (n_phase == PH_RST_LOW);
			busy_q         <= (n_phase != PH_IDLE);
			done_q         <= done_c;
			rejected_q     <= rej_c;
			read_data_q    <= rdata_c;
			presence_out_q <= n_presence;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.drive_low = drive_low_q;
	assign rsp.busy_res  = busy_q;
	assign rsp.done_res  = done_q;
	assign rsp.rejected  = rejected_q;
	assign rsp.read_data = read_data_q;
	assign rsp.presence  = presence_out_q;

`ifndef NO_ASSERTIONS
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (tick_count_q != '0))
		else $error("active phase with zero tick count");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && done_q) |-> !busy_q)
		else $error("completion reported while still busy");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rejected_q) |-> (busy_q && !done_q))
		else $error("rejection reported while idle");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && drive_low_q) |-> busy_q)
		else $error("bus driven low while idle");

	a_rdata_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (read_data_q != '0)) |-> done_q)
		else $error("read data without completion");

	a_cmd_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && (phase_q == PH_IDLE) && (cmd.kind == KIND_RESET)) |=>
		(phase_q == PH_RST_LOW))
		else $error("bus reset command did not start the low pulse");
`endif

endmodule

// File: verif/tb.sv
// Self-checking testbench for the 1-Wire bus master: directed and random traffic against a built-in predictor.
module tb;
	import owb_pkg::*;

	localparam int COUNT_BITS = 10;
	localparam int CNT_MAX = (1 << COUNT_BITS) - 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 400;
	localparam int PHASE_ITEMS = 150;
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam logic [2:0] REG_NONE = 3'd7;
	localparam int LINE_LOW = 0;
	localparam int LINE_HIGH = 1;
	localparam int LINE_ANY = 2;

	typedef struct packed {
		logic [2:0]        kind;
		logic [DATA_W-1:0] data;
		logic              line;
	} cmd_beat_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy;
		logic              done;
		logic              rejected;
		logic [DATA_W-1:0] rdata;
		logic              presence;
	} rsp_beat_t;

	typedef struct packed {
		logic [6:0][REG_W-1:0] regs;
		phase_t                phase;
		logic [COUNT_BITS-1:0] left_ticks;
		logic [3:0]            bits_left;
		logic [DATA_W-1:0]     shreg;
		logic                  rd_op;
		logic                  byte_op;
		logic                  pres;
		logic                  cur_bit;
	} wire_state_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en;
	logic [2:0]       cfg_index;
	logic [REG_W-1:0] cfg_wdata;

	owb_cmd_if cmd_if ();
	owb_rsp_if rsp_if ();

	one_wire_bus_master #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.rsp       (rsp_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	wire_state_t gen_st;
	wire_state_t chk_st;
	cmd_beat_t   pend_q[$];
	rsp_beat_t   want_q[$];
	int          errors = 0;
	int          rsp_count = 0;
	int          idle_cycles = 0;
	int          gen_items = 0;
	int          cmd_wait = 0;
	int          cmd_calm = 0;
	int          rsp_wait = 0;
	int          rsp_calm = 0;
	bit          cmd_took = 1'b0;

	always #5 clk = ~clk;

	function automatic wire_state_t state_at_reset();
		wire_state_t s;
		s = '0;
		s.regs[REG_ONE_LOW] = ONE_LOW_RST;
		s.regs[REG_ZERO_LOW] = ZERO_LOW_RST;
		s.regs[REG_RESET_LOW] = RESET_LOW_RST;
		s.regs[REG_PRESENCE_WAIT] = PRESENCE_WAIT_RST;
		s.regs[REG_RESET_TAIL] = RESET_TAIL_RST;
		s.regs[REG_SAMPLE_WAIT] = SAMPLE_WAIT_RST;
		s.regs[REG_READ_TAIL] = READ_TAIL_RST;
		s.phase = PH_IDLE;
		return s;
	endfunction

	function automatic logic [COUNT_BITS-1:0] clamp_len(int v, bit at_least_one);
		if (at_least_one && v == 0) v = 1;
		if (v > CNT_MAX) v = CNT_MAX;
		return COUNT_BITS'(v);
	endfunction

	function automatic void slot_begin(inout wire_state_t s);
		s.phase = PH_LOW;
		if (s.rd_op) begin
			s.left_ticks = clamp_len(int'(READ_LOW_TICKS), 1'b1);
		end else begin
			s.cur_bit = s.shreg[0];
			s.left_ticks = clamp_len(s.cur_bit ? int'(s.regs[REG_ONE_LOW]) :
				int'(s.regs[REG_ZERO_LOW]), 1'b1);
		end
	endfunction

	function automatic logic [COUNT_BITS-1:0] high_len(wire_state_t s);
		int t;
		t = int'(ZERO_HIGH_TICKS);
		if (s.cur_bit && s.regs[REG_ZERO_LOW] > s.regs[REG_ONE_LOW])
			t = int'(s.regs[REG_ZERO_LOW]) + int'(ZERO_HIGH_TICKS) - int'(s.regs[REG_ONE_LOW]);
		if (t < int'(ZERO_HIGH_TICKS)) t = int'(ZERO_HIGH_TICKS);
		return clamp_len(t, 1'b1);
	endfunction

	function automatic bit slot_end(inout wire_state_t s, inout logic [DATA_W-1:0] rdata);
		bit fin;
		fin = 1'b0;
		if (s.bits_left != 4'd0) begin
			s.bits_left = s.bits_left - 4'd1;
			if (!s.rd_op) s.shreg = s.shreg >> 1;
			slot_begin(s);
		end else begin
			s.phase = PH_IDLE;
			if (s.rd_op) rdata = s.byte_op ? s.shreg : {7'd0, s.cur_bit};
			fin = 1'b1;
		end
		return fin;
	endfunction

	function automatic bit tick_advance(inout wire_state_t s, input logic line,
		inout logic [DATA_W-1:0] rdata);
		bit fin;
		fin = 1'b0;
		if (s.phase != PH_IDLE) begin
			s.left_ticks = s.left_ticks - 1'b1;
			if (s.left_ticks == '0) begin
				case (s.phase)
				PH_LOW: begin
					if (s.rd_op) begin
						s.phase = PH_SAMPLE;
						s.left_ticks = clamp_len(int'(s.regs[REG_SAMPLE_WAIT]), 1'b1);
					end else begin
						s.phase = PH_RELEASE;
						s.left_ticks = high_len(s);
					end
				end
				PH_RELEASE, PH_TAIL: begin
					fin = slot_end(s, rdata);
				end
				PH_SAMPLE: begin
					s.cur_bit = line;
					s.shreg = {line, s.shreg[DATA_W-1:1]};
					if (s.regs[REG_READ_TAIL] == '0) begin
						fin = slot_end(s, rdata);
					end else begin
						s.phase = PH_TAIL;
						s.left_ticks = clamp_len(int'(s.regs[REG_READ_TAIL]), 1'b0);
					end
				end
				PH_RST_LOW: begin
					s.phase = PH_RST_WAIT;
					s.left_ticks = clamp_len(int'(s.regs[REG_PRESENCE_WAIT]), 1'b1);
				end
				PH_RST_WAIT: begin
					s.pres = !line;
					if (s.regs[REG_RESET_TAIL] == '0) begin
						s.phase = PH_IDLE;
						fin = 1'b1;
					end else begin
						s.phase = PH_RST_TAIL;
						s.left_ticks = clamp_len(int'(s.regs[REG_RESET_TAIL]), 1'b0);
					end
				end
				default: begin
					s.phase = PH_IDLE;
					fin = 1'b1;
				end
				endcase
			end
		end
		return fin;
	endfunction

	function automatic void command_begin(inout wire_state_t s, input logic [2:0] k,
		input logic [DATA_W-1:0] d);
		s.bits_left = 4'd0;
		s.shreg = '0;
		s.byte_op = 1'b0;
		s.rd_op = 1'b0;
		if (k == KIND_RESET) begin
			s.phase = PH_RST_LOW;
			s.left_ticks = clamp_len(int'(s.regs[REG_RESET_LOW]), 1'b1);
		end else begin
			s.rd_op = (k == KIND_READ_BIT || k == KIND_READ_BYTE);
			if (k == KIND_WRITE_BYTE || k == KIND_READ_BYTE) begin
				s.byte_op = 1'b1;
				s.bits_left = BYTE_BITS_LEFT;
			end
			if (k == KIND_WRITE_BIT) s.shreg = {7'd0, d[0]};
			if (k == KIND_WRITE_BYTE) s.shreg = d;
			slot_begin(s);
		end
	endfunction

	function automatic rsp_beat_t bus_step(inout wire_state_t s, input cmd_beat_t c);
		rsp_beat_t r;
		logic [DATA_W-1:0] rdata;
		bit fin;
		bit rej;
		rdata = '0;
		fin = 1'b0;
		rej = 1'b0;
		if (c.kind == KIND_TICK) begin
			fin = tick_advance(s, c.line, rdata);
		end else if (c.kind <= KIND_READ_BYTE) begin
			if (s.phase != PH_IDLE) rej = 1'b1;
			else command_begin(s, c.kind, c.data);
		end
		r.drive_low = (s.phase == PH_LOW || s.phase == PH_RST_LOW);
		r.busy = (s.phase != PH_IDLE);
		r.done = fin;
		r.rejected = rej;
		r.rdata = rdata;
		r.presence = s.pres;
		return r;
	endfunction

	function automatic int draw_gap(inout int calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (r < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic int rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 0;
		if (r < 75) return $urandom_range(1, 6);
		if (r < 95) return $urandom_range(7, 20);
		return $urandom_range(21, 40);
	endfunction

	function automatic logic pick_line(int mode);
		if (mode == LINE_ANY) return 1'($urandom_range(0, 1));
		return (mode == LINE_HIGH);
	endfunction

	task automatic push_beat(input logic [2:0] k, input logic [DATA_W-1:0] d, input logic l);
		cmd_beat_t c;
		c.kind = k;
		c.data = d;
		c.line = l;
		void'(bus_step(gen_st, c));
		pend_q.push_back(c);
		gen_items++;
	endtask

	task automatic finish_op(input int mode, input int noise_pct, input int cut);
		int n;
		n = 0;
		while (gen_st.phase != PH_IDLE && (cut == 0 || n < cut)) begin
			if ($urandom_range(0, 99) < noise_pct)
				push_beat(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
			push_beat(KIND_TICK, 8'($urandom), pick_line(mode));
			n++;
		end
	endtask

	task automatic run_op(input logic [2:0] k, input logic [DATA_W-1:0] d, input int mode,
		input int noise_pct, input int cut);
		push_beat(k, d, pick_line(mode));
		finish_op(mode, noise_pct, cut);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= REG_W'(val);
		if (idx <= REG_READ_TAIL) gen_st.regs[idx] = REG_W'(val);
	endtask

	task automatic load_timing(input int one_low, input int zero_low, input int rst_low,
		input int pres_wait, input int rst_tail, input int smp_wait, input int rd_tail,
		input bit stray);
		write_reg(REG_ONE_LOW, one_low);
		write_reg(REG_ZERO_LOW, zero_low);
		write_reg(REG_RESET_LOW, rst_low);
		write_reg(REG_PRESENCE_WAIT, pres_wait);
		write_reg(REG_RESET_TAIL, rst_tail);
		write_reg(REG_SAMPLE_WAIT, smp_wait);
		write_reg(REG_READ_TAIL, rd_tail);
		if (stray) write_reg(REG_NONE, $urandom_range(0, CNT_MAX));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (pend_q.size() != 0 || cmd_if.valid || want_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin : driver
		cmd_beat_t nb;
		if (arst_n) begin
			if (!cmd_if.valid || cmd_took) begin
				if (cmd_wait > 0) begin
					cmd_if.valid <= 1'b0;
					cmd_wait--;
				end else if (pend_q.size() != 0) begin
					nb = pend_q.pop_front();
					cmd_if.valid <= 1'b1;
					cmd_if.kind <= nb.kind;
					cmd_if.write_data <= nb.data;
					cmd_if.line_level <= nb.line;
					cmd_wait = draw_gap(cmd_calm);
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
			if (rsp_wait > 0) begin
				rsp_if.ready <= 1'b0;
				rsp_wait--;
			end else begin
				rsp_if.ready <= 1'b1;
				rsp_wait = draw_gap(rsp_calm);
			end
		end
	end

	always @(posedge clk) begin : monitor
		rsp_beat_t want;
		rsp_beat_t got;
		cmd_beat_t c;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_wr_en && cfg_index <= REG_READ_TAIL)
				chk_st.regs[cfg_index] = cfg_wdata;
			if (rsp_if.valid && rsp_if.ready) begin
				moved = 1'b1;
				got.drive_low = rsp_if.drive_low;
				got.busy = rsp_if.busy_res;
				got.done = rsp_if.done_res;
				got.rejected = rsp_if.rejected;
				got.rdata = rsp_if.read_data;
				got.presence = rsp_if.presence;
				if (want_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("tb: result beat %0d with nothing expected", rsp_count);
				end else begin
					want = want_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"tb: result beat %0d: expected drive_low=%0b busy=%0b done=%0b",
								" rejected=%0b read_data=%02h presence=%0b, got drive_low=%0b busy=%0b",
								" done=%0b rejected=%0b read_data=%02h presence=%0b"}, rsp_count,
								want.drive_low, want.busy, want.done, want.rejected, want.rdata,
								want.presence, got.drive_low, got.busy, got.done, got.rejected,
								got.rdata, got.presence);
					end
				end
				rsp_count++;
			end
			if (cmd_if.valid && cmd_if.ready) begin
				moved = 1'b1;
				c.kind = cmd_if.kind;
				c.data = cmd_if.write_data;
				c.line = cmd_if.line_level;
				want_q.push_back(bus_step(chk_st, c));
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
		cmd_took <= arst_n && cmd_if.valid && cmd_if.ready;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int rand_items;
		int items0;
		rand_items = 0;
		cmd_if.valid = 1'b0;
		cmd_if.kind = KIND_TICK;
		cmd_if.write_data = '0;
		cmd_if.line_level = 1'b0;
		rsp_if.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		gen_st = state_at_reset();
		chk_st = state_at_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_op(KIND_WRITE_BIT, 8'h01, LINE_ANY, 0, 0);
		run_op(KIND_READ_BIT, 8'h00, LINE_ANY, 0, 0);
		settle();

		load_timing(2, 4, 3, 2, 0, 1, 0, 1'b0);
		run_op(KIND_RESET, 8'h00, LINE_LOW, 0, 0);
		run_op(KIND_RESET, 8'hFF, LINE_HIGH, 0, 0);
		run_op(KIND_WRITE_BIT, 8'hFE, LINE_ANY, 0, 0);
		run_op(KIND_WRITE_BIT, 8'h01, LINE_ANY, 0, 0);
		run_op(KIND_READ_BIT, 8'h00, LINE_HIGH, 0, 0);
		run_op(KIND_READ_BIT, 8'hFF, LINE_LOW, 0, 0);
		run_op(KIND_WRITE_BYTE, 8'h00, LINE_ANY, 0, 0);
		run_op(KIND_WRITE_BYTE, 8'hFF, LINE_ANY, 0, 0);
		run_op(KIND_READ_BYTE, 8'h00, LINE_ANY, 0, 0);
		push_beat(KIND_SPARE_A, 8'hFF, 1'b1);
		push_beat(KIND_SPARE_B, 8'h00, 1'b0);
		push_beat(KIND_RESET, 8'h00, 1'b1);
		push_beat(KIND_WRITE_BYTE, 8'hA5, 1'b0);
		push_beat(KIND_SPARE_B, 8'h5A, 1'b1);
		push_beat(KIND_READ_BIT, 8'h00, 1'b0);
		finish_op(LINE_LOW, 0, 0);
		settle();

		load_timing(3, 1, 2, 1, 4, 2, 3, 1'b0);
		run_op(KIND_RESET, 8'h00, LINE_ANY, 0, 0);
		run_op(KIND_READ_BYTE, 8'h00, LINE_ANY, 0, 0);
		run_op(KIND_WRITE_BYTE, 8'hA5, LINE_ANY, 0, 0);
		settle();

		load_timing(0, 0, 0, 0, 0, 0, 0, 1'b1);
		items0 = gen_items;
		while (gen_items - items0 < PHASE_ITEMS)
			run_op(3'($urandom_range(int'(KIND_RESET), int'(KIND_READ_BYTE))), 8'($urandom),
				LINE_ANY, 5, 0);
		settle();

		while (rand_items < RANDOM_ITEMS) begin
			load_timing(rand_len(), rand_len(), rand_len(), rand_len(), rand_len(), rand_len(),
				rand_len(), $urandom_range(0, 99) < 30);
			items0 = gen_items;
			while (gen_items - items0 < PHASE_ITEMS) begin
				run_op(3'($urandom_range(int'(KIND_RESET), int'(KIND_READ_BYTE))), 8'($urandom),
					LINE_ANY, 4, ($urandom_range(0, 99) < 5) ? $urandom_range(1, 12) : 0);
				if ($urandom_range(0, 99) < 30)
					repeat ($urandom_range(1, 4)) push_beat(KIND_TICK, 8'($urandom), 1'($urandom));
				if ($urandom_range(0, 99) < 3)
					push_beat($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B, 8'($urandom),
						1'($urandom));
			end
			settle();
			rand_items += gen_items - items0;
		end

		settle();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
